// File: rtl/bba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

	localparam int MAX_BLOCKS = 65536;
	localparam int WORD_BITS  = 32;
	localparam int MAP_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int ADDR_W     = $clog2(MAP_WORDS);
	localparam int BIT_W      = $clog2(WORD_BITS);

	localparam int KIND_W = 3;
	localparam int IDX_W  = 16;
	localparam int CNT_W  = 17;
	localparam int STS_W  = 2;
	localparam int CFG_W  = 17;

	localparam logic [CNT_W-1:0] MAX_BLOCKS_C = CNT_W'(MAX_BLOCKS);
	localparam logic [CNT_W-1:0] COUNT_MAX    = {CNT_W{1'b1}};

	localparam logic [KIND_W-1:0] KIND_ALLOC   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_READ    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_INIT    = 3'd4;

	localparam logic [STS_W-1:0] STS_OK           = 2'd0;
	localparam logic [STS_W-1:0] STS_NO_FREE      = 2'd1;
	localparam logic [STS_W-1:0] STS_RANGE        = 2'd2;
	localparam logic [STS_W-1:0] STS_ALREADY_FREE = 2'd3;

	localparam logic CFG_TOTAL    = 1'b0;
	localparam logic CFG_RESERVED = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_RMW,
		ST_RESP
	} bba_state_t;

	typedef struct packed {
		logic [CNT_W-1:0] eff_total;
		logic [CNT_W-1:0] eff_reserved;
	} bba_cfg_t;

	typedef struct packed {
		logic                 we;
		logic [ADDR_W-1:0]    addr;
		logic [WORD_BITS-1:0] data;
	} bba_wr_t;

	// position of the first clear bit, counted from the msb
	function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] word);
		logic [BIT_W-1:0] pos;
		pos = '0;
		for (int r = WORD_BITS - 1; r >= 0; r--) begin
			if (!word[WORD_BITS-1-r]) begin
				pos = BIT_W'(r);
			end
		end
		return pos;
	endfunction

	function automatic logic [WORD_BITS-1:0] bit_mask(input logic [BIT_W-1:0] r);
		return {1'b1, {(WORD_BITS-1){1'b0}}} >> r;
	endfunction

	// map word contents after init with resv leading blocks used
	function automatic logic [WORD_BITS-1:0] init_word(input logic [ADDR_W-1:0] w,
			input logic [CNT_W-1:0] resv);
		logic [CNT_W-BIT_W-1:0] resv_w;
		logic [CNT_W-BIT_W-1:0] w_ext;
		logic [WORD_BITS-1:0]   word;
		resv_w = resv[CNT_W-1:BIT_W];
		w_ext  = (CNT_W-BIT_W)'(w);
		if (w_ext < resv_w) begin
			word = {WORD_BITS{1'b1}};
		end else if (w_ext == resv_w) begin
			word = ~({WORD_BITS{1'b1}} >> resv[BIT_W-1:0]);
		end else begin
			word = '0;
		end
		return word;
	endfunction

endpackage

`default_nettype wire

// File: rtl/bba_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bba_req_if import bba_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [IDX_W-1:0]  block_index;
	logic              new_bit;

	modport source (output valid, kind, block_index, new_bit, input ready);
	modport sink (input valid, kind, block_index, new_bit, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [STS_W-1:0] status;
	logic [IDX_W-1:0] result_index;
	logic             bit_value;
	logic [CNT_W-1:0] free_count;

	modport source (output valid, status, result_index, bit_value, free_count, input ready);
	modport sink (input valid, status, result_index, bit_value, free_count, output ready);
endinterface

`default_nettype wire

// File: rtl/bba_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/bba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bba_ctrl import bba_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire bba_cfg_t             cfg,
	bba_req_if.sink                   req,
	bba_rsp_if.source                 rsp,
	output bba_wr_t                   wr,
	output logic     [ADDR_W-1:0]     raddr,
	input  wire logic [WORD_BITS-1:0] rdata
);

	bba_state_t state_q, state_d;

	logic [CNT_W-1:0]  free_q;
	logic [ADDR_W-1:0] hint_q;
	logic [ADDR_W-1:0] scan_w_q;
	logic [ADDR_W-1:0] clr_q;
	logic              init_q;
	logic [CNT_W-1:0]  resv_pat_q;
	logic              out_valid_q;

	logic [KIND_W-1:0] kind_q;
	logic [IDX_W-1:0]  idx_q;
	logic              nb_q;
	logic [STS_W-1:0]  res_status_q;
	logic [IDX_W-1:0]  res_index_q;
	logic              res_bit_q;
	logic [STS_W-1:0]  out_status_q;
	logic [IDX_W-1:0]  out_index_q;
	logic              out_bit_q;
	logic [CNT_W-1:0]  out_free_q;

	logic              acc;
	logic              out_free;
	logic              req_range;
	logic              clr_last;
	logic              word_full;
	logic [BIT_W-1:0]  zero_pos;
	logic [IDX_W-1:0]  scan_n;
	logic              base_ge;
	logic              n_ge;
	logic              scan_last;
	logic              scan_hit;
	logic              scan_fail;
	logic [ADDR_W-1:0] idx_word;
	logic [WORD_BITS-1:0] idx_mask;
	logic              cur_bit;
	logic [ADDR_W-1:0] hint_min;

	assign acc       = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign req_range = {1'b0, req.block_index} >= cfg.eff_total;
	assign clr_last  = clr_q == ADDR_W'(MAP_WORDS - 1);

	assign word_full = &rdata;
	assign zero_pos  = first_zero(rdata);
	assign scan_n    = IDX_W'({scan_w_q, zero_pos});
	assign base_ge   = {{(CNT_W-ADDR_W-BIT_W){1'b0}}, scan_w_q, {BIT_W{1'b0}}} >= cfg.eff_total;
	assign n_ge      = {{(CNT_W-ADDR_W-BIT_W){1'b0}}, scan_w_q, zero_pos} >= cfg.eff_total;
	assign scan_last = scan_w_q == ADDR_W'(MAP_WORDS - 1);
	assign scan_hit  = !base_ge && !word_full && !n_ge;
	assign scan_fail = base_ge || (word_full && scan_last) || (!word_full && n_ge);

	assign idx_word = idx_q[BIT_W +: ADDR_W];
	assign idx_mask = bit_mask(idx_q[BIT_W-1:0]);
	assign cur_bit  = |(rdata & idx_mask);
	// words below the hint are known to be full
	assign hint_min = (idx_word < hint_q) ? idx_word : hint_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = init_q ? ST_RESP : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (acc) begin
					case (req.kind) inside
						KIND_ALLOC: state_d = (free_q == '0) ? ST_RESP : ST_SCAN;
						KIND_RELEASE, KIND_READ, KIND_WRITE: begin
							state_d = req_range ? ST_RESP : ST_RMW;
						end
						KIND_INIT: state_d = ST_CLEAR;
						default: state_d = ST_RESP;
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_hit || scan_fail) begin
					state_d = ST_RESP;
				end
			end
			ST_RMW: state_d = ST_RESP;
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		raddr     = hint_q;
		wr        = '0;
		unique case (state_q)
			ST_CLEAR: begin
				wr.we   = 1'b1;
				wr.addr = clr_q;
				wr.data = init_word(clr_q, resv_pat_q);
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				raddr     = (req.kind == KIND_ALLOC) ? hint_q : req.block_index[BIT_W +: ADDR_W];
			end
			ST_SCAN: begin
				raddr   = scan_w_q + ADDR_W'(1);
				wr.we   = scan_hit;
				wr.addr = scan_w_q;
				wr.data = rdata | bit_mask(zero_pos);
			end
			ST_RMW: begin
				wr.addr = idx_word;
				case (kind_q)
					KIND_RELEASE: begin
						wr.we   = cur_bit;
						wr.data = rdata & ~idx_mask;
					end
					KIND_WRITE: begin
						wr.we   = 1'b1;
						wr.data = nb_q ? (rdata | idx_mask) : (rdata & ~idx_mask);
					end
					default: wr.we = 1'b0;
				endcase
			end
			ST_RESP: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			free_q      <= '0;
			hint_q      <= '0;
			scan_w_q    <= '0;
			clr_q       <= '0;
			init_q      <= 1'b0;
			resv_pat_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_last) begin
						init_q <= 1'b0;
					end
				end
				ST_IDLE: begin
					scan_w_q <= hint_q;
					if (acc && req.kind == KIND_INIT) begin
						free_q     <= cfg.eff_total - cfg.eff_reserved;
						resv_pat_q <= cfg.eff_reserved;
						init_q     <= 1'b1;
						clr_q      <= '0;
						hint_q     <= '0;
					end
				end
				ST_SCAN: begin
					scan_w_q <= scan_w_q + ADDR_W'(1);
					if (scan_hit) begin
						free_q <= free_q - CNT_W'(1);
						hint_q <= scan_w_q;
					end
				end
				ST_RMW: begin
					if (kind_q == KIND_RELEASE && cur_bit) begin
						if (free_q != COUNT_MAX) begin
							free_q <= free_q + CNT_W'(1);
						end
						hint_q <= hint_min;
					end else if (kind_q == KIND_WRITE && !nb_q) begin
						hint_q <= hint_min;
					end
				end
				ST_RESP: ;
				default: ;
			endcase
			if (state_q == ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			kind_q    <= req.kind;
			idx_q     <= req.block_index;
			nb_q      <= req.new_bit;
			res_bit_q <= 1'b0;
			case (req.kind) inside
				KIND_ALLOC: begin
					res_status_q <= STS_NO_FREE;
					res_index_q  <= '0;
				end
				KIND_RELEASE, KIND_READ, KIND_WRITE: begin
					res_status_q <= req_range ? STS_RANGE : STS_OK;
					res_index_q  <= req.block_index;
				end
				KIND_INIT: begin
					res_status_q <= STS_OK;
					res_index_q  <= '0;
				end
				default: begin
					res_status_q <= STS_OK;
					res_index_q  <= req.block_index;
				end
			endcase
		end
		if (state_q == ST_SCAN && scan_hit) begin
			res_status_q <= STS_OK;
			res_index_q  <= scan_n;
			res_bit_q    <= 1'b1;
		end
		if (state_q == ST_RMW) begin
			case (kind_q)
				KIND_RELEASE: res_status_q <= cur_bit ? STS_OK : STS_ALREADY_FREE;
				KIND_READ: res_bit_q <= cur_bit;
				KIND_WRITE: res_bit_q <= nb_q;
				default: ;
			endcase
		end
		if (state_q == ST_RESP && out_free) begin
			out_status_q <= res_status_q;
			out_index_q  <= res_index_q;
			out_bit_q    <= res_bit_q;
			out_free_q   <= free_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.result_index = out_index_q;
	assign rsp.bit_value    = out_bit_q;
	assign rsp.free_count   = out_free_q;

`ifndef SYNTH
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_RESP) |-> !wr.we)
		else $error("map written outside an operation");

	a_alloc_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && wr.we) |=> free_q == $past(free_q) - CNT_W'(1))
		else $error("allocate did not take one free block");

	a_out_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_RESP)
		else $error("result shown without a finished request");

	a_nofree_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == STS_NO_FREE) |-> !out_bit_q)
		else $error("failed allocate reports a used bit");
`endif

endmodule

`default_nettype wire

// File: rtl/bitmap_block_allocator_core.sv
// in-range read, write and release pass through the read-modify-write state before the response state
// out-of-range indices, unused kinds and allocate with a zero free count go straight to the response state
// allocate: scans map words in order, starting from the lowest possibly free word
// init: rewrites all 2048 map words, one per cycle, then responds
// one request in flight; the next is taken the cycle after its result is loaded for output
// after reset all 2048 map words are cleared with ready low; config writes are always taken
`timescale 1ns / 1ps
`default_nettype none

module bitmap_block_allocator_core import bba_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	bba_req_if.sink               req,
	bba_rsp_if.source             rsp
);

	logic [CNT_W-1:0]     total_q;
	logic [CNT_W-1:0]     reserved_q;
	bba_cfg_t             cfg;
	bba_wr_t              wr;
	logic [ADDR_W-1:0]    raddr;
	logic [WORD_BITS-1:0] rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= MAX_BLOCKS_C;
			reserved_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TOTAL: total_q <= cfg_wdata;
				CFG_RESERVED: reserved_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// clamp the total to the map capacity and the reserved count to the clamped total
	always_comb begin
		cfg.eff_total    = (total_q > MAX_BLOCKS_C) ? MAX_BLOCKS_C : total_q;
		cfg.eff_reserved = (reserved_q > cfg.eff_total) ? cfg.eff_total : reserved_q;
	end

	bba_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk  (clk),
		.we   (wr.we),
		.waddr(wr.addr),
		.wdata(wr.data),
		.raddr(raddr),
		.rdata(rdata)
	);

	bba_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.req   (req),
		.rsp   (rsp),
		.wr    (wr),
		.raddr (raddr),
		.rdata (rdata)
	);

endmodule

`default_nettype wire

// File: dv/bitmap_block_allocator_core_tb.sv
`timescale 1ns / 1ps

module bitmap_block_allocator_core_tb;
	import bba_pkg::*;

	localparam int CYCLE_LIMIT  = 5_000_000;
	localparam int RANDOM_ITEMS = 500;
	localparam int QUIET_ITEMS  = 75;
	localparam int MAX_REPORTS  = 100;
	localparam int unsigned REG_MASK = 32'h1FFFF;

	// first of the three kinds the block does nothing with
	localparam logic [KIND_W-1:0] KIND_SPARE = KIND_INIT + 3'd1;

	typedef struct packed {
		logic [STS_W-1:0] status;
		logic [IDX_W-1:0] result_index;
		logic             bit_value;
		logic [CNT_W-1:0] free_count;
	} alloc_rsp_t;

	class alloc_scoreboard;
		logic [WORD_BITS-1:0] used_words [MAP_WORDS];
		int unsigned          free_cnt;
		int unsigned          total_reg;
		int unsigned          reserved_reg;
		alloc_rsp_t           expected_q[$];
		int                   errors;

		function new();
			foreach (used_words[w]) used_words[w] = '0;
			free_cnt     = 0;
			total_reg    = MAX_BLOCKS;
			reserved_reg = 0;
			errors       = 0;
		endfunction

		function void set_reg(logic idx, int unsigned value);
			if (idx == CFG_TOTAL) begin
				total_reg = value & REG_MASK;
			end else begin
				reserved_reg = value & REG_MASK;
			end
		endfunction

		function int unsigned eff_size();
			return (total_reg > MAX_BLOCKS) ? MAX_BLOCKS : total_reg;
		endfunction

		// block n sits msb-first inside its word
		function logic [WORD_BITS-1:0] mask_of(int unsigned n);
			return WORD_BITS'(1) << (WORD_BITS - 1 - (n % WORD_BITS));
		endfunction

		function bit is_used(int unsigned n);
			return (used_words[n / WORD_BITS] & mask_of(n)) != '0;
		endfunction

		function void mark(int unsigned n, bit v);
			if (v) begin
				used_words[n / WORD_BITS] |= mask_of(n);
			end else begin
				used_words[n / WORD_BITS] &= ~mask_of(n);
			end
		endfunction

		function bit lowest_free(int unsigned limit, output int unsigned found);
			int unsigned n;
			found = 0;
			for (int unsigned w = 0; w < MAP_WORDS; w++) begin
				if (w * WORD_BITS >= limit) return 0;
				if (&used_words[w]) continue;
				for (int unsigned r = 0; r < WORD_BITS; r++) begin
					n = w * WORD_BITS + r;
					if (n >= limit) return 0;
					if (!is_used(n)) begin
						found = n;
						return 1;
					end
				end
			end
			return 0;
		endfunction

		function void note_request(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx, logic nb);
			alloc_rsp_t  exp;
			int unsigned size;
			int unsigned resv;
			int unsigned n;
			size             = eff_size();
			exp.status       = STS_OK;
			exp.result_index = idx;
			exp.bit_value    = 1'b0;
			case (kind)
				KIND_ALLOC: begin
					exp.result_index = '0;
					if (free_cnt == 0 || !lowest_free(size, n)) begin
						exp.status = STS_NO_FREE;
					end else begin
						mark(n, 1'b1);
						free_cnt--;
						exp.result_index = n[IDX_W-1:0];
						exp.bit_value    = 1'b1;
					end
				end
				KIND_RELEASE, KIND_READ, KIND_WRITE: begin
					if (idx >= size) begin
						exp.status = STS_RANGE;
					end else if (kind == KIND_RELEASE) begin
						if (!is_used(idx)) begin
							exp.status = STS_ALREADY_FREE;
						end else begin
							mark(idx, 1'b0);
							if (free_cnt < COUNT_MAX) free_cnt++;
						end
					end else if (kind == KIND_READ) begin
						exp.bit_value = is_used(idx);
					end else begin
						mark(idx, nb);
						exp.bit_value = nb;
					end
				end
				KIND_INIT: begin
					resv = (reserved_reg > size) ? size : reserved_reg;
					foreach (used_words[w]) used_words[w] = '0;
					for (n = 0; n < resv; n++) mark(n, 1'b1);
					free_cnt         = size - resv;
					exp.result_index = '0;
				end
				default: begin
				end
			endcase
			exp.free_count = free_cnt[CNT_W-1:0];
			expected_q.push_back(exp);
		endfunction

		function void check_response(alloc_rsp_t got);
			alloc_rsp_t exp;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: response with no request outstanding: status %0d index %0d bit %0d count %0d",
						$time, got.status, got.result_index, got.bit_value, got.free_count);
				return;
			end
			exp = expected_q.pop_front();
			if (got !== exp) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: mismatch exp status %0d index %0d bit %0d count %0d, got status %0d index %0d bit %0d count %0d",
						$time, exp.status, exp.result_index, exp.bit_value, exp.free_count,
						got.status, got.result_index, got.bit_value, got.free_count);
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_wdata;
	bit               idling = 1'b1;
	int               cycle_cnt = 0;

	bba_req_if req_if ();
	bba_rsp_if rsp_if ();

	alloc_scoreboard sb = new();

	bitmap_block_allocator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("[bitmap_block_allocator_core] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready)
			sb.check_response('{rsp_if.status, rsp_if.result_index, rsp_if.bit_value,
				rsp_if.free_count});
	end

	// result side back-pressure
	initial begin
		int hold;
		hold = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				rsp_if.ready <= 1'b0;
			end else if (idling && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 10) - 1;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	task automatic put_request(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx, logic nb);
		int gap;
		if (idling && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid       <= 1'b1;
		req_if.kind        <= kind;
		req_if.block_index <= idx;
		req_if.new_bit     <= nb;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		sb.note_request(kind, idx, nb);
	endtask

	task automatic settle();
		req_if.valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_config(int unsigned total, int unsigned reserved);
		sb.set_reg(CFG_TOTAL, total);
		sb.set_reg(CFG_RESERVED, reserved);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_TOTAL;
		cfg_wdata <= total[CFG_W-1:0];
		@(posedge clk);
		cfg_index <= CFG_RESERVED;
		cfg_wdata <= reserved[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_op();
		int unsigned size;
		int unsigned pick;
		logic [IDX_W-1:0] in_idx;
		logic [IDX_W-1:0] out_idx;
		logic [KIND_W-1:0] kind;
		size    = sb.eff_size();
		in_idx  = (size == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, size - 1));
		out_idx = (size >= MAX_BLOCKS) ? IDX_W'($urandom) : IDX_W'($urandom_range(size, 65535));
		pick    = $urandom_range(0, 99);
		if (pick < 35) begin
			put_request(KIND_ALLOC, IDX_W'($urandom), 1'($urandom));
		end else if (pick < 55) begin
			put_request(KIND_RELEASE, in_idx, 1'($urandom));
		end else if (pick < 70) begin
			put_request(KIND_READ, in_idx, 1'($urandom));
		end else if (pick < 82) begin
			put_request(KIND_WRITE, in_idx, 1'($urandom));
		end else if (pick < 85) begin
			put_request(KIND_INIT, IDX_W'($urandom), 1'($urandom));
		end else if (pick < 91) begin
			kind = KIND_SPARE + KIND_W'($urandom_range(0, 2));
			put_request(kind, IDX_W'($urandom), 1'($urandom));
		end else begin
			case ($urandom_range(0, 2))
				0: kind = KIND_RELEASE;
				1: kind = KIND_READ;
				default: kind = KIND_WRITE;
			endcase
			put_request(kind, out_idx, 1'($urandom));
		end
	endtask

	initial begin
		int unsigned total;
		int unsigned reserved;
		int          n_items;
		int          sent;
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= CFG_TOTAL;
		cfg_wdata          <= '0;
		req_if.valid       <= 1'b0;
		req_if.kind        <= KIND_ALLOC;
		req_if.block_index <= '0;
		req_if.new_bit     <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// before any init: count is zero and the map is clear
		put_request(KIND_ALLOC, 16'h0000, 1'b0);
		put_request(KIND_READ, 16'hFFFF, 1'b0);
		put_request(KIND_RELEASE, 16'h0000, 1'b0);
		put_request(KIND_WRITE, 16'hFFFF, 1'b1);
		put_request(KIND_RELEASE, 16'hFFFF, 1'b0);
		put_request(KIND_SPARE + 3'd2, 16'hFFFF, 1'b1);
		put_request(KIND_INIT, 16'h0000, 1'b0);
		put_request(KIND_ALLOC, 16'h0000, 1'b0);
		put_request(KIND_ALLOC, 16'h0000, 1'b0);
		put_request(KIND_READ, 16'h0001, 1'b0);

		// map full through writes while the count says otherwise
		settle();
		write_config(4, 0);
		put_request(KIND_INIT, 16'h0000, 1'b0);
		for (int i = 0; i < 4; i++) put_request(KIND_WRITE, IDX_W'(i), 1'b1);
		put_request(KIND_ALLOC, 16'h0000, 1'b0);
		put_request(KIND_READ, 16'h0004, 1'b0);
		put_request(KIND_RELEASE, 16'h0003, 1'b0);
		put_request(KIND_ALLOC, 16'h0000, 1'b0);

		// size above the maximum, reserved beyond size
		settle();
		write_config(REG_MASK, REG_MASK);
		put_request(KIND_INIT, 16'h0000, 1'b0);
		put_request(KIND_READ, 16'hFFFF, 1'b0);
		put_request(KIND_RELEASE, 16'd40000, 1'b0);
		put_request(KIND_ALLOC, 16'h0000, 1'b0);

		// zero size: nothing is in range
		settle();
		write_config(0, 5);
		put_request(KIND_INIT, 16'h0000, 1'b0);
		put_request(KIND_READ, 16'h0000, 1'b0);
		put_request(KIND_WRITE, 16'h0000, 1'b1);
		put_request(KIND_SPARE, 16'h1234, 1'b0);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: begin
					total    = MAX_BLOCKS;
					reserved = $urandom_range(0, MAX_BLOCKS);
					n_items  = 12;
				end
				1: begin
					total    = $urandom_range(MAX_BLOCKS + 1, REG_MASK);
					reserved = $urandom_range(0, REG_MASK);
					n_items  = 12;
				end
				2: begin
					total    = $urandom_range(0, 1);
					reserved = $urandom_range(0, 3);
					n_items  = 15;
				end
				default: begin
					total    = $urandom_range(2, 96);
					reserved = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, total + 4);
					n_items  = $urandom_range(25, 60);
				end
			endcase
			settle();
			write_config(total, reserved);
			// now and then keep the old map across a size change
			if ($urandom_range(0, 7) != 0) begin
				put_request(KIND_INIT, IDX_W'($urandom), 1'($urandom));
				sent++;
			end
			for (int i = 0; i < n_items && sent < RANDOM_ITEMS; i++) begin
				idling = (sent < RANDOM_ITEMS - QUIET_ITEMS);
				random_op();
				sent++;
			end
		end

		settle();
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("[bitmap_block_allocator_core] OK");
		end else begin
			$display("[bitmap_block_allocator_core] ERROR");
		end
		$finish;
	end

endmodule
